/* rtl/bss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_pkg: shared types and constants
// Beat formats, command codes and sizing for the bounded sequence store.
// ----------------------------------------------------------------------------
package bss_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int POS_W        = 6;
    localparam int VAL_W        = 32;
    localparam int CMDQ_DEPTH   = 2;

    localparam logic [1:0] FUNC_INSERT_FRONT = 2'd0;
    localparam logic [1:0] FUNC_APPEND       = 2'd1;
    localparam logic [1:0] FUNC_REMOVE       = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_REMOVE
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]              func;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] element;
        logic                    last;
        logic                    empty_res;
        logic                    dropped;
    } rsp_t;

    typedef struct packed {
        op_t                     op;
        logic                    dropped;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } cmd_t;

endpackage

/* rtl/bss_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_front: request classifier
// Accepts request beats, tracks the element count and turns each request
// into a resolved command (op, drop flag) for the command queue.
// ----------------------------------------------------------------------------
module bss_front #(
    parameter int CAPACITY = bss_pkg::CAPACITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  bss_pkg::req_t req,
    input  logic          q_full,
    output logic          q_push,
    output bss_pkg::cmd_t q_cmd
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > bss_pkg::POS_W) ? CNT_W : bss_pkg::POS_W;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             is_full;
    logic             pos_ok;

    assign req_stall = q_full;
    assign q_push    = req_valid && !q_full;
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign pos_ok    = (CMP_W'(req.position) < CMP_W'(count_reg));

    always_comb
    begin
        q_cmd.op       = bss_pkg::OP_NONE;
        q_cmd.dropped  = 1'b0;
        q_cmd.value    = req.value;
        q_cmd.position = req.position;
        count_next     = count_reg;
        unique case (req.func)
            bss_pkg::FUNC_INSERT_FRONT, bss_pkg::FUNC_APPEND:
            begin
                if (is_full)
                begin
                    q_cmd.dropped = 1'b1;
                end
                else
                begin
                    q_cmd.op   = (req.func == bss_pkg::FUNC_INSERT_FRONT) ?
                                 bss_pkg::OP_PUSH_FRONT : bss_pkg::OP_PUSH_BACK;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            bss_pkg::FUNC_REMOVE:
            begin
                if (pos_ok)
                begin
                    q_cmd.op   = bss_pkg::OP_REMOVE;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (q_push)
        begin
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/bss_cmd_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_cmd_fifo: command queue
// Short FIFO between the classifier and the executor.
// ----------------------------------------------------------------------------
module bss_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bss_pkg::cmd_t wr_cmd,
    input  logic          pop,
    output bss_pkg::cmd_t rd_cmd,
    output logic          full,
    output logic          empty
);

    localparam int DEPTH = bss_pkg::CMDQ_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    bss_pkg::cmd_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [LVL_W-1:0] level_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (level_reg == LVL_W'(DEPTH));
    assign empty   = (level_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_cmd  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                level_reg <= level_reg + LVL_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                level_reg <= level_reg - LVL_W'(1);
            end
        end
    end

endmodule

/* rtl/bss_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_back: executor and emitter
// Applies each command to the shifting element file in its execute state, then
// walks the sequence out front to back by rotating the occupied entries.
// ----------------------------------------------------------------------------
module bss_back #(
    parameter int CAPACITY = bss_pkg::CAPACITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  bss_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bss_pkg::rsp_t rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > bss_pkg::POS_W) ? CNT_W : bss_pkg::POS_W;

    bss_pkg::state_t                  state_reg;
    bss_pkg::state_t                  state_next;
    bss_pkg::cmd_t                    cmd_reg;
    logic [CNT_W-1:0]                 count_reg;
    logic [CNT_W-1:0]                 count_next;
    logic [CNT_W-1:0]                 idx_reg;
    logic                             drop_reg;
    logic signed [bss_pkg::VAL_W-1:0] entries_reg  [CAPACITY];
    logic signed [bss_pkg::VAL_W-1:0] entries_next [CAPACITY];

    logic             is_empty;
    logic             is_last;
    logic             beat_out;
    logic             rotate;
    logic [CNT_W-1:0] count_m1;

    assign is_empty = (count_reg == '0);
    assign count_m1 = count_reg - CNT_W'(1);
    assign is_last  = is_empty || (idx_reg == count_m1);
    assign beat_out = rsp_valid && !rsp_stall;
    assign rotate   = beat_out && !is_empty;

    assign rsp.element   = is_empty ? '0 : entries_reg[0];
    assign rsp.last      = is_last;
    assign rsp.empty_res = is_empty;
    assign rsp.dropped   = drop_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bss_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = bss_pkg::ST_EXEC;
                end
            end
            bss_pkg::ST_EXEC:
            begin
                state_next = bss_pkg::ST_EMIT;
            end
            bss_pkg::ST_EMIT:
            begin
                if (beat_out && is_last)
                begin
                    state_next = q_empty ? bss_pkg::ST_IDLE : bss_pkg::ST_EXEC;
                end
            end
            default:
            begin
                state_next = bss_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        rsp_valid = 1'b0;
        q_pop     = 1'b0;
        unique case (state_reg)
            bss_pkg::ST_IDLE:
            begin
                q_pop = !q_empty;
            end
            bss_pkg::ST_EXEC:
            begin
            end
            bss_pkg::ST_EMIT:
            begin
                rsp_valid = 1'b1;
                q_pop     = !rsp_stall && is_last && !q_empty;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (state_reg == bss_pkg::ST_EXEC)
        begin
            unique case (cmd_reg.op)
                bss_pkg::OP_PUSH_FRONT, bss_pkg::OP_PUSH_BACK:
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                bss_pkg::OP_REMOVE:
                begin
                    count_next = count_m1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            entries_next[i] = entries_reg[i];
            if (state_reg == bss_pkg::ST_EXEC)
            begin
                unique case (cmd_reg.op)
                    bss_pkg::OP_PUSH_FRONT:
                    begin
                        entries_next[i] = (i == 0) ? cmd_reg.value
                                                   : entries_reg[(i == 0) ? 0 : i - 1];
                    end
                    bss_pkg::OP_PUSH_BACK:
                    begin
                        if (CNT_W'(i) == count_reg)
                        begin
                            entries_next[i] = cmd_reg.value;
                        end
                    end
                    bss_pkg::OP_REMOVE:
                    begin
                        if (CMP_W'(i) >= CMP_W'(cmd_reg.position))
                        begin
                            entries_next[i] = entries_reg[(i == CAPACITY - 1) ? i : i + 1];
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (rotate)
            begin
                if (CNT_W'(i) == count_m1)
                begin
                    entries_next[i] = entries_reg[0];
                end
                else if (CNT_W'(i) < count_m1)
                begin
                    entries_next[i] = entries_reg[(i == CAPACITY - 1) ? i : i + 1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            entries_reg[i] <= entries_next[i];
        end
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bss_pkg::ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == bss_pkg::ST_EXEC)
            begin
                idx_reg  <= '0;
                drop_reg <= cmd_reg.dropped;
            end
            else if (beat_out)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
        end
    end

endmodule

/* rtl/bounded_sequence_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_sequence_store: bounded ordered list of signed 32-bit values
// A request passes through the command queue, a command load and an update
// state before its first result beat. The executor then lists the whole
// sequence, one element per cycle unless the receiver stalls; the queue
// keeps taking requests meanwhile until it is full.
// Reset clears the count and the command queue; stored values are undefined.
// ----------------------------------------------------------------------------
module bounded_sequence_store #(
    parameter int CAPACITY = bss_pkg::CAPACITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  bss_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bss_pkg::rsp_t rsp
);

    logic          q_full;
    logic          q_empty;
    logic          q_push;
    logic          q_pop;
    bss_pkg::cmd_t q_wr_cmd;
    bss_pkg::cmd_t q_rd_cmd;

    bss_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_wr_cmd)
    );

    bss_cmd_fifo u_cmdq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_cmd (q_wr_cmd),
        .pop    (q_pop),
        .rd_cmd (q_rd_cmd),
        .full   (q_full),
        .empty  (q_empty)
    );

    bss_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_cmd     (q_rd_cmd),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for bounded_sequence_store
// Sends front inserts, appends, removes and unused commands, keeps its own
// copy of the stored list, and checks every listing beat in order, field by
// field. Both handshakes are throttled at random, and one long receiver
// hold-off lets the block fill up and stall its request side.
// ----------------------------------------------------------------------------
module tb;

    localparam int         CAP            = bss_pkg::CAPACITY_DEF;
    localparam logic [1:0] FUNC_NOP       = 2'd3;
    localparam int         WATCHDOG_LIMIT = 3000;
    localparam int         DRAIN_CYCLES   = 40;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_stall;
    bss_pkg::req_t req       = '0;
    logic          rsp_valid;
    logic          rsp_stall = 1'b0;
    bss_pkg::rsp_t rsp;

    logic signed [bss_pkg::VAL_W-1:0] model_list[$];
    bss_pkg::rsp_t                    listing_q[$];
    int                               mismatch_count = 0;
    int                               send_idle_pct  = 0;
    int                               recv_idle_pct  = 0;
    int                               hold_len       = 0;
    int                               hold_token     = 0;
    int                               hold_seen      = 0;
    int                               hold_left      = 0;
    int                               quiet_cycles   = 0;

    bounded_sequence_store u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Update the list copy and queue the listing that the request produces.
    function automatic void apply_request(bss_pkg::req_t r);
        bss_pkg::rsp_t beat;
        logic          drop;
        drop = 1'b0;
        case (r.func)
            bss_pkg::FUNC_INSERT_FRONT:
            begin
                if (model_list.size() >= CAP)
                    drop = 1'b1;
                else
                    model_list.push_front(r.value);
            end
            bss_pkg::FUNC_APPEND:
            begin
                if (model_list.size() >= CAP)
                    drop = 1'b1;
                else
                    model_list.push_back(r.value);
            end
            bss_pkg::FUNC_REMOVE:
            begin
                if (r.position < model_list.size())
                    model_list.delete(r.position);
            end
            default:
            begin
            end
        endcase
        if (model_list.size() == 0)
        begin
            beat.element   = '0;
            beat.last      = 1'b1;
            beat.empty_res = 1'b1;
            beat.dropped   = drop;
            listing_q.push_back(beat);
        end
        else
        begin
            for (int k = 0; k < model_list.size(); k++)
            begin
                beat.element   = model_list[k];
                beat.last      = (k == model_list.size() - 1);
                beat.empty_res = 1'b0;
                beat.dropped   = drop;
                listing_q.push_back(beat);
            end
        end
    endfunction

    task automatic send_request(input logic [1:0] func,
                                input logic signed [bss_pkg::VAL_W-1:0] value,
                                input logic [bss_pkg::POS_W-1:0] position);
        bss_pkg::req_t r;
        r.func     = func;
        r.value    = value;
        r.position = position;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        apply_request(r);
    endtask

    function automatic logic [bss_pkg::POS_W-1:0] pick_position();
        if (model_list.size() > 0 && $urandom_range(99) < 80)
            return bss_pkg::POS_W'($urandom_range(model_list.size() - 1));
        return bss_pkg::POS_W'($urandom_range(63));
    endfunction

    task automatic test_empty_list();
        send_request(bss_pkg::FUNC_REMOVE, $urandom, 6'd0);
        send_request(FUNC_NOP, $urandom, 6'd0);
        send_request(bss_pkg::FUNC_REMOVE, $urandom, 6'd63);
    endtask

    task automatic test_value_extremes();
        send_request(bss_pkg::FUNC_INSERT_FRONT, 32'sh7FFF_FFFF, 6'd0);
        send_request(bss_pkg::FUNC_APPEND, 32'sh8000_0000, 6'd63);
        send_request(bss_pkg::FUNC_INSERT_FRONT, -32'sd1, 6'd0);
        send_request(bss_pkg::FUNC_APPEND, 32'sd0, 6'd0);
        send_request(FUNC_NOP, $urandom, 6'd1);
    endtask

    task automatic test_remove_positions();
        send_request(bss_pkg::FUNC_REMOVE, $urandom, 6'd63);
        send_request(bss_pkg::FUNC_REMOVE, $urandom, 6'd4);
        send_request(bss_pkg::FUNC_REMOVE, $urandom, 6'd1);
        send_request(bss_pkg::FUNC_REMOVE, $urandom, 6'd2);
        send_request(bss_pkg::FUNC_REMOVE, $urandom, 6'd0);
        send_request(bss_pkg::FUNC_REMOVE, $urandom, 6'd0);
        send_request(bss_pkg::FUNC_APPEND, 32'sd1, 6'd0);
        send_request(bss_pkg::FUNC_REMOVE, $urandom, 6'd0);
    endtask

    task automatic test_full_store();
        while (model_list.size() < CAP)
            send_request($urandom_range(1) ? bss_pkg::FUNC_APPEND : bss_pkg::FUNC_INSERT_FRONT,
                         $urandom, bss_pkg::POS_W'($urandom_range(63)));
        send_request(bss_pkg::FUNC_INSERT_FRONT, $urandom, 6'd0);
        send_request(bss_pkg::FUNC_APPEND, $urandom, 6'd0);
        send_request(FUNC_NOP, $urandom, 6'd5);
        send_request(bss_pkg::FUNC_REMOVE, $urandom, 6'd63);
        send_request(bss_pkg::FUNC_REMOVE, $urandom, bss_pkg::POS_W'(CAP));
        send_request(bss_pkg::FUNC_REMOVE, $urandom, bss_pkg::POS_W'(CAP - 1));
        send_request(bss_pkg::FUNC_APPEND, $urandom, 6'd0);
        while (model_list.size() > 0)
            send_request(bss_pkg::FUNC_REMOVE, $urandom, pick_position());
    endtask

    task automatic test_random_mix(input int n);
        int roll;
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 5)
                send_request(FUNC_NOP, $urandom, bss_pkg::POS_W'($urandom_range(63)));
            else if (roll < 60)
                send_request($urandom_range(1) ? bss_pkg::FUNC_APPEND
                                               : bss_pkg::FUNC_INSERT_FRONT,
                             $urandom, bss_pkg::POS_W'($urandom_range(63)));
            else
                send_request(bss_pkg::FUNC_REMOVE, $urandom, pick_position());
        end
    endtask

    task automatic test_backpressure();
        hold_len   = 300;
        hold_token = hold_token + 1;
        for (int i = 0; i < 16; i++)
        begin
            if ($urandom_range(2) != 0)
                send_request($urandom_range(1) ? bss_pkg::FUNC_APPEND
                                               : bss_pkg::FUNC_INSERT_FRONT,
                             $urandom, bss_pkg::POS_W'($urandom_range(63)));
            else
                send_request(bss_pkg::FUNC_REMOVE, $urandom, pick_position());
        end
    endtask

    // Receiver: check accepted beats, then pick the stall for the next cycle.
    always @(posedge clk)
    begin : rsp_side
        bss_pkg::rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid === 1'b1 && rsp_stall == 1'b0)
            begin
                if (listing_q.size() == 0)
                begin
                    $error("unexpected beat: element %0d", rsp.element);
                    mismatch_count++;
                end
                else
                begin
                    want = listing_q.pop_front();
                    if (rsp.element !== want.element)
                    begin
                        $error("element: expected %0d, got %0d", want.element, rsp.element);
                        mismatch_count++;
                    end
                    if (rsp.last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, rsp.last);
                        mismatch_count++;
                    end
                    if (rsp.empty_res !== want.empty_res)
                    begin
                        $error("empty_res: expected %0b, got %0b", want.empty_res,
                               rsp.empty_res);
                        mismatch_count++;
                    end
                    if (rsp.dropped !== want.dropped)
                    begin
                        $error("dropped: expected %0b, got %0b", want.dropped, rsp.dropped);
                        mismatch_count++;
                    end
                end
            end
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                hold_left = hold_len;
            end
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else
                rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 26;
        recv_idle_pct = 75;
        test_empty_list();
        test_value_extremes();
        test_remove_positions();
        test_full_store();

        send_idle_pct = 75;
        recv_idle_pct = 26;
        test_random_mix(90);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random_mix(60);

        req_valid <= 1'b0;
        while (listing_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/bss_pkg.sv
rtl/bss_front.sv
rtl/bss_cmd_fifo.sv
rtl/bss_back.sv
rtl/bounded_sequence_store.sv
sim/tb.sv
